>>> rtl/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared codes and result type for the distance-vector route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

    localparam logic [2:0] FN_LOAD = 3'd0;
    localparam logic [2:0] FN_UPD  = 3'd1;
    localparam logic [2:0] FN_LOOK = 3'd2;
    localparam logic [2:0] FN_ADV  = 3'd3;
    localparam logic [2:0] FN_TICK = 3'd4;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_TABLE_FULL  = 4'd1;
    localparam logic [3:0] ST_UNKNOWN_SRC = 4'd2;
    localparam logic [3:0] ST_FORWARDED   = 4'd3;
    localparam logic [3:0] ST_DELIVERED   = 4'd4;
    localparam logic [3:0] ST_DROP_UNKN   = 4'd5;
    localparam logic [3:0] ST_DROP_NOROUT = 4'd6;
    localparam logic [3:0] ST_DROP_DEAD   = 4'd7;
    localparam logic [3:0] ST_ADV_ENTRY   = 4'd8;
    localparam logic [3:0] ST_NOTHING     = 4'd9;
    localparam logic [3:0] ST_TICK_DONE   = 4'd10;

    localparam logic       REG_OWN_NODE = 1'b0;
    localparam logic       REG_LIVENESS = 1'b1;

    localparam int         MAX_RESULTS = 16;
    localparam int         RES_CNT_W   = 5;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] out_port;
        logic [7:0]  entry_node;
        logic [15:0] entry_cost;
        logic        table_changed;
        logic        last_of_run;
    } t_res;

endpackage

>>> rtl/dvrt_mem.sv
// ----------------------------------------------------------------------------
// dvrt_mem
// Route entry storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dvrt_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 82
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/dvrt_core.sv
// ----------------------------------------------------------------------------
// dvrt_core
// Sequencer that scans the route table with one compare, one adder and one
// age unit, and holds the result output register.
// ----------------------------------------------------------------------------
module dvrt_core #(
    parameter int TABLE_DEPTH = 16,
    parameter int COST_BITS   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [2:0]       i_func,
    input  logic [7:0]       i_node_id,
    input  logic [7:0]       i_from_node,
    input  logic [15:0]      i_cost_value,
    input  logic [15:0]      i_port_number,
    input  logic [7:0]       i_own_node,
    input  logic [7:0]       i_liveness_limit,
    output logic             o_valid,
    input  logic             i_stall,
    output dvrt_pkg::t_res   o_res
);

    localparam int C  = COST_BITS;
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [C-1:0]  INF   = {C{1'b1}};
    localparam logic [CW-1:0] DEPTH = CW'(TABLE_DEPTH);
    localparam int RES_CNT_W_L = dvrt_pkg::RES_CNT_W;

    typedef struct packed {
        logic [7:0]   tag;
        logic         adj;
        logic [C-1:0] link;
        logic [C-1:0] path;
        logic [7:0]   via;
        logic         viav;
        logic [15:0]  last;
        logic [15:0]  port;
    } t_rec;

    typedef enum logic [4:0] {
        S_IDLE, S_SRD, S_SCMP, S_LOAD, S_USRC, S_UDST, S_LK1, S_LK2, S_DCHK,
        S_DRES, S_LKF, S_ARD, S_ACMP, S_AOUT, S_TRD, S_TCMP, S_JRD, S_JCHK,
        S_EMIT
    } t_state;

    function automatic logic [15:0] cap16(input logic [C-1:0] c);
        logic [32:0] w;
        w = 33'(c);
        return (w > 33'h0FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [C-1:0] in_cost(input logic [15:0] v);
        logic [32:0] w;
        w = {17'd0, v};
        return (v == 16'hFFFF || w > 33'(INF)) ? INF : C'(w);
    endfunction

    function automatic dvrt_pkg::t_res mk_res(input logic [3:0]  st,
                                              input logic [7:0]  nd,
                                              input logic [15:0] c,
                                              input logic        last);
        dvrt_pkg::t_res r;
        r             = '0;
        r.status      = st;
        r.entry_node  = nd;
        r.entry_cost  = c;
        r.last_of_run = last;
        return r;
    endfunction

    t_state          r_state, r_ret, r_dret, r_eret;
    logic [2:0]      r_func;
    logic [7:0]      r_node, r_from, r_key;
    logic [C-1:0]    r_cost, r_sum;
    logic [15:0]     r_port, r_tick;
    logic [CW-1:0]   r_count, r_idx, r_i;
    logic [IW-1:0]   r_fidx;
    logic            r_found, r_dead, r_chg, r_pv, r_ov;
    t_rec            r_rec;
    logic [7:0]      r_tgt_tag, r_p_node;
    logic [15:0]     r_tgt_port, r_p_cost;
    logic [C-1:0]    r_tgt_cost;
    logic [RES_CNT_W_L-1:0] r_n;
    dvrt_pkg::t_res  r_res, r_out;

    t_rec            rd, wd;
    logic [$bits(t_rec)-1:0] mem_rd;
    logic            we;
    logic [IW-1:0]   wa, ra;
    logic [C:0]      sum_w;
    logic [C-1:0]    sum_sat, known;
    logic [15:0]     age_last, age;
    logic            age_dead, room, upd, jhit;

    dvrt_mem #(.DEPTH(TABLE_DEPTH), .WIDTH($bits(t_rec))) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wa),
        .i_wdata (wd),
        .i_raddr (ra),
        .o_rdata (mem_rd)
    );

    assign rd       = t_rec'(mem_rd);
    assign sum_w    = {1'b0, r_cost} + {1'b0, r_rec.link};
    assign sum_sat  = sum_w[C] ? INF : sum_w[C-1:0];
    assign age_last = (r_state == S_TCMP) ? rd.last : r_rec.last;
    assign age      = r_tick - age_last;
    assign age_dead = age > {8'd0, i_liveness_limit};
    assign room     = r_count < DEPTH;
    assign upd      = (r_sum < r_rec.path) ||
                      (r_rec.viav && r_rec.via == r_from && r_sum != r_rec.path);
    assign jhit     = rd.viav && rd.via == r_rec.tag;
    assign known    = (r_rec.adj && !(r_rec.viav && r_rec.path < r_rec.link)) ?
                      r_rec.link : r_rec.path;
    assign ra       = (r_state == S_ARD || r_state == S_TRD) ? r_i[IW-1:0] :
                      r_idx[IW-1:0];

    always_comb begin
        we = 1'b0;
        wa = r_fidx;
        wd = r_rec;
        case (r_state)
            S_LOAD: begin
                if (r_found) begin
                    we      = 1'b1;
                    wd.adj  = 1'b1;
                    wd.link = r_cost;
                    wd.port = r_port;
                    wd.last = r_tick;
                end else if (room) begin
                    we      = 1'b1;
                    wa      = r_count[IW-1:0];
                    wd.tag  = r_node;
                    wd.adj  = 1'b1;
                    wd.link = r_cost;
                    wd.path = INF;
                    wd.via  = 8'd0;
                    wd.viav = 1'b0;
                    wd.last = r_tick;
                    wd.port = r_port;
                end
            end
            S_USRC: begin
                if (r_found && r_rec.adj) begin
                    we      = 1'b1;
                    wd.last = r_tick;
                end
            end
            S_UDST: begin
                if (r_found) begin
                    we      = upd;
                    wd.path = r_sum;
                    wd.via  = r_from;
                    wd.viav = 1'b1;
                end else if (room) begin
                    we      = 1'b1;
                    wa      = r_count[IW-1:0];
                    wd.tag  = r_node;
                    wd.adj  = 1'b0;
                    wd.link = '0;
                    wd.path = r_sum;
                    wd.via  = r_from;
                    wd.viav = 1'b1;
                    wd.last = 16'd0;
                    wd.port = 16'd0;
                end
            end
            S_JCHK: begin
                we      = jhit;
                wa      = r_idx[IW-1:0];
                wd      = rd;
                wd.path = INF;
                wd.viav = 1'b0;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_tick  <= 16'd0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && !i_stall && r_state != S_EMIT) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_func <= i_func;
                        r_node <= i_node_id;
                        r_from <= i_from_node;
                        r_cost <= in_cost(i_cost_value);
                        r_port <= i_port_number;
                        r_idx  <= '0;
                        r_i    <= '0;
                        r_n    <= '0;
                        r_pv   <= 1'b0;
                        r_chg  <= 1'b0;
                        r_eret <= S_IDLE;
                        r_res  <= (i_func == dvrt_pkg::FN_LOOK &&
                                   i_node_id == i_own_node) ?
                                  mk_res(dvrt_pkg::ST_DELIVERED, 8'd0, 16'd0, 1'b1) : '0;
                        case (i_func)
                            dvrt_pkg::FN_LOAD: begin
                                r_key   <= i_node_id;
                                r_ret   <= S_LOAD;
                                r_state <= S_SRD;
                            end
                            dvrt_pkg::FN_UPD: begin
                                r_key   <= i_from_node;
                                r_ret   <= S_USRC;
                                r_state <= S_SRD;
                            end
                            dvrt_pkg::FN_LOOK: begin
                                if (i_node_id == i_own_node) begin
                                    r_state <= S_EMIT;
                                end else begin
                                    r_key   <= i_node_id;
                                    r_ret   <= S_LK1;
                                    r_state <= S_SRD;
                                end
                            end
                            dvrt_pkg::FN_ADV: begin
                                r_dret  <= S_AOUT;
                                r_state <= S_ARD;
                            end
                            dvrt_pkg::FN_TICK: begin
                                r_tick  <= r_tick + 16'd1;
                                r_state <= S_TRD;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SRD: begin
                    if (r_idx == r_count) begin
                        r_found <= 1'b0;
                        r_state <= r_ret;
                    end else begin
                        r_state <= S_SCMP;
                    end
                end
                S_SCMP: begin
                    if (rd.tag == r_key) begin
                        r_found <= 1'b1;
                        r_fidx  <= r_idx[IW-1:0];
                        r_rec   <= rd;
                        r_state <= r_ret;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_LOAD: begin
                    r_res.last_of_run <= 1'b1;
                    r_state           <= S_EMIT;
                    if (r_found || room) begin
                        if (!r_found) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_res.status        <= dvrt_pkg::ST_OK;
                        r_res.table_changed <= 1'b1;
                    end else begin
                        r_res.status <= dvrt_pkg::ST_TABLE_FULL;
                    end
                end
                S_USRC: begin
                    if (!r_found || !r_rec.adj) begin
                        r_res.status      <= dvrt_pkg::ST_UNKNOWN_SRC;
                        r_res.last_of_run <= 1'b1;
                        r_state           <= S_EMIT;
                    end else begin
                        r_sum   <= sum_sat;
                        r_key   <= r_node;
                        r_idx   <= '0;
                        r_ret   <= S_UDST;
                        r_state <= S_SRD;
                    end
                end
                S_UDST: begin
                    r_res.last_of_run <= 1'b1;
                    r_state           <= S_EMIT;
                    if (r_found) begin
                        r_res.status        <= dvrt_pkg::ST_OK;
                        r_res.table_changed <= upd;
                    end else if (room) begin
                        r_count             <= r_count + 1'b1;
                        r_res.status        <= dvrt_pkg::ST_OK;
                        r_res.table_changed <= 1'b1;
                    end else begin
                        r_res.status <= dvrt_pkg::ST_TABLE_FULL;
                    end
                end
                S_LK1: begin
                    r_dret <= S_LKF;
                    if (!r_found) begin
                        r_res.status      <= dvrt_pkg::ST_DROP_UNKN;
                        r_res.last_of_run <= 1'b1;
                        r_state           <= S_EMIT;
                    end else if (r_rec.adj) begin
                        r_state <= S_DCHK;
                    end else if (!r_rec.viav) begin
                        r_res.status      <= dvrt_pkg::ST_DROP_NOROUT;
                        r_res.last_of_run <= 1'b1;
                        r_state           <= S_EMIT;
                    end else begin
                        r_key   <= r_rec.via;
                        r_idx   <= '0;
                        r_ret   <= S_LK2;
                        r_state <= S_SRD;
                    end
                end
                S_LK2: begin
                    if (!r_found) begin
                        r_res.status      <= dvrt_pkg::ST_DROP_NOROUT;
                        r_res.last_of_run <= 1'b1;
                        r_state           <= S_EMIT;
                    end else begin
                        r_state <= S_DCHK;
                    end
                end
                S_DCHK: begin
                    r_tgt_tag  <= r_rec.tag;
                    r_tgt_port <= r_rec.port;
                    r_tgt_cost <= known;
                    if (r_rec.adj) begin
                        r_dead  <= age_dead;
                        r_state <= r_dret;
                    end else if (!r_rec.viav) begin
                        r_dead  <= 1'b1;
                        r_state <= r_dret;
                    end else begin
                        r_key   <= r_rec.via;
                        r_idx   <= '0;
                        r_ret   <= S_DRES;
                        r_state <= S_SRD;
                    end
                end
                S_DRES: begin
                    r_dead  <= !r_found || age_dead;
                    r_state <= r_dret;
                end
                S_LKF: begin
                    r_res.entry_node  <= r_tgt_tag;
                    r_res.last_of_run <= 1'b1;
                    r_state           <= S_EMIT;
                    if (r_dead) begin
                        r_res.status <= dvrt_pkg::ST_DROP_DEAD;
                    end else begin
                        r_res.status   <= dvrt_pkg::ST_FORWARDED;
                        r_res.out_port <= r_tgt_port;
                    end
                end
                S_ARD: begin
                    if (r_i == r_count ||
                        r_n == RES_CNT_W_L'(dvrt_pkg::MAX_RESULTS)) begin
                        r_eret  <= S_IDLE;
                        r_state <= S_EMIT;
                        r_res   <= r_pv ?
                                   mk_res(dvrt_pkg::ST_ADV_ENTRY, r_p_node, r_p_cost, 1'b1) :
                                   mk_res(dvrt_pkg::ST_NOTHING, 8'd0, 16'd0, 1'b1);
                    end else begin
                        r_state <= S_ACMP;
                    end
                end
                S_ACMP: begin
                    r_i <= r_i + 1'b1;
                    if (rd.tag == r_node) begin
                        r_state <= S_ARD;
                    end else begin
                        r_rec   <= rd;
                        r_state <= S_DCHK;
                    end
                end
                S_AOUT: begin
                    r_n      <= r_n + 1'b1;
                    r_pv     <= 1'b1;
                    r_p_node <= r_tgt_tag;
                    r_p_cost <= r_dead ? cap16(INF) : cap16(r_tgt_cost);
                    if (r_pv) begin
                        r_res   <= mk_res(dvrt_pkg::ST_ADV_ENTRY, r_p_node, r_p_cost, 1'b0);
                        r_eret  <= S_ARD;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_ARD;
                    end
                end
                S_TRD: begin
                    if (r_i == r_count) begin
                        r_res.status        <= dvrt_pkg::ST_TICK_DONE;
                        r_res.table_changed <= r_chg;
                        r_res.last_of_run   <= 1'b1;
                        r_state             <= S_EMIT;
                    end else begin
                        r_state <= S_TCMP;
                    end
                end
                S_TCMP: begin
                    r_rec <= rd;
                    if (rd.adj && age_dead) begin
                        r_idx   <= '0;
                        r_state <= S_JRD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_TRD;
                    end
                end
                S_JRD: begin
                    if (r_idx == r_count) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_TRD;
                    end else begin
                        r_state <= S_JCHK;
                    end
                end
                S_JCHK: begin
                    if (jhit) begin
                        r_chg <= 1'b1;
                    end
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_JRD;
                end
                S_EMIT: begin
                    if (!r_ov || !i_stall) begin
                        r_ov    <= 1'b1;
                        r_out   <= r_res;
                        r_state <= r_eret;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ov;
    assign o_res   = r_out;

endmodule

>>> rtl/distance_vector_route_table_top.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table_top
// Distance-vector route table with an APB-style register port.
//
//   channel   direction  handshake            payload
//   command   in         i_valid / o_stall    i_func .. i_port_number
//   result    out        o_valid / i_stall    o_status .. o_last_of_run
//   config    in         psel/penable/pready  paddr, pwdata, prdata
//
// Each table entry visited passes through a memory-read state and a compare state.
// Lookup: up to three table searches; advertise: one pass plus a search per
// routed entry; tick: one pass plus a full pass for each dead neighbor.
// Reset clears the fill count, the tick and the result valid flag.
// A stalled result holds the sequencer only when another result is due.
// ----------------------------------------------------------------------------
module distance_vector_route_table_top #(
    parameter int TABLE_DEPTH = 16,
    parameter int COST_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_node_id,
    input  logic [7:0]  i_from_node,
    input  logic [15:0] i_cost_value,
    input  logic [15:0] i_port_number,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_status,
    output logic [15:0] o_out_port,
    output logic [7:0]  o_entry_node,
    output logic [15:0] o_entry_cost,
    output logic        o_table_changed,
    output logic        o_last_of_run,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]     r_own_node, r_liveness;
    dvrt_pkg::t_res res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_node <= 8'd0;
            r_liveness <= 8'd6;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == dvrt_pkg::REG_OWN_NODE) begin
                r_own_node <= pwdata[7:0];
            end else begin
                r_liveness <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == dvrt_pkg::REG_LIVENESS) ? {24'd0, r_liveness} :
                                                           {24'd0, r_own_node};
    assign pready = 1'b1;

    dvrt_core #(.TABLE_DEPTH(TABLE_DEPTH), .COST_BITS(COST_BITS)) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_node_id        (i_node_id),
        .i_from_node      (i_from_node),
        .i_cost_value     (i_cost_value),
        .i_port_number    (i_port_number),
        .i_own_node       (r_own_node),
        .i_liveness_limit (r_liveness),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_res            (res)
    );

    assign o_status        = res.status;
    assign o_out_port      = res.out_port;
    assign o_entry_node    = res.entry_node;
    assign o_entry_cost    = res.entry_cost;
    assign o_table_changed = res.table_changed;
    assign o_last_of_run   = res.last_of_run;

endmodule
